@@ design/packed_pattern_channel_scanner_macros.svh @@
// Assertion macros for the packed pattern channel scanner.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef PACKED_PATTERN_CHANNEL_SCANNER_MACROS_SVH
`define PACKED_PATTERN_CHANNEL_SCANNER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPCS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppcs assertion failed");
`define PPCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ppcs assertion failed");
`else
`define PPCS_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define PPCS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ design/ppcs_pkg.sv @@
// Package for the packed pattern channel scanner: word types and constants.
// Used by packed_pattern_channel_scanner; depends on nothing.
`default_nettype none
package ppcs_pkg;

    localparam int CH_SLOTS   = 64;
    localparam int CH_IDX_W   = $clog2(CH_SLOTS);
    localparam int CNT_W      = CH_IDX_W + 1;
    localparam int SKIP_W     = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic [1:0] STATUS_BUSY    = 2'd0;
    localparam logic [1:0] STATUS_DONE    = 2'd1;
    localparam logic [1:0] STATUS_CORRUPT = 2'd2;

    localparam logic [1:0] MODE_CONTINUE = 2'd0;

    localparam logic REG_PAN_ENABLE = 1'b0;
    localparam logic REG_INSTR_MODE = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [7:0] row_total;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]          parse_status;
        logic [CH_SLOTS-1:0] used_channels;
        logic [CNT_W-1:0]    channel_count;
    } out_word_t;

endpackage
`default_nettype wire

@@ design/packed_pattern_channel_scanner.sv @@
// Packed pattern channel scanner top level: input register, row parser, result register.
// Depends on ppcs_pkg and packed_pattern_channel_scanner_macros.svh.
//
// Channel   Direction  Ports                                  Word
// s_        in         s_valid, s_ready, s_word               ppcs_pkg::in_word_t
// m_        out        m_valid, m_ready, m_word               ppcs_pkg::out_word_t
// APB       in         psel, penable, pwrite, paddr, pwdata   registers at 0x0 and 0x8
//
// A word is accepted every cycle unless the output stalls; its result is registered.
// The mask table read is registered at acceptance and forwarded past a pending write.
// Reset clears all control state and the mask table valid bits at once.
// A stalled result holds in the output register; the input register then fills and stops.
`default_nettype none
`include "packed_pattern_channel_scanner_macros.svh"
module packed_pattern_channel_scanner (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ppcs_pkg::in_word_t                   s_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ppcs_pkg::out_word_t                  m_word,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ppcs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ppcs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ppcs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    typedef enum logic [1:0] {PH_CHANNEL, PH_MASK, PH_SKIP} phase_t;

    logic [ppcs_pkg::CH_SLOTS-1:0]   pan_reg;
    logic                            imode_reg;

    logic                            st_vld_reg;
    ppcs_pkg::in_word_t              st_word_reg;
    logic [7:0]                      rd_data_reg;
    logic                            fwd_hit_reg;
    logic [7:0]                      fwd_data_reg;

    logic [7:0]                      mask_mem [ppcs_pkg::CH_SLOTS];
    logic [ppcs_pkg::CH_SLOTS-1:0]   mask_vld_reg;

    logic [7:0]                      rows_reg, rows_next;
    phase_t                          phase_reg, phase_next;
    logic [ppcs_pkg::SKIP_W-1:0]     skip_reg, skip_next;
    logic [ppcs_pkg::CH_IDX_W-1:0]   ch_reg, ch_next;
    logic [1:0]                      outcome_reg, outcome_next;
    logic [ppcs_pkg::CH_SLOTS-1:0]   used_reg, used_next;
    logic [ppcs_pkg::CNT_W-1:0]      count_reg, count_next;

    logic                            out_vld_reg;
    ppcs_pkg::out_word_t             out_word_reg;

    logic                            advance;
    logic                            s_acc;
    logic                            clr_tbl;
    logic                            wr_tbl;
    logic                            wr_en;
    logic [7:0]                      lookup;
    logic                            ended_step;

    assign advance = st_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !st_vld_reg || advance;
    assign s_acc   = s_valid && s_ready;
    assign m_valid = out_vld_reg;
    assign m_word  = out_word_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[3] == ppcs_pkg::REG_INSTR_MODE)
                     ? {{(ppcs_pkg::APB_DATA_W-1){1'b0}}, imode_reg} : pan_reg;
    assign wr_en   = advance && wr_tbl;
    assign ended_step = advance && (outcome_reg != ppcs_pkg::STATUS_BUSY)
                        && (st_word_reg.mode == ppcs_pkg::MODE_CONTINUE);

    assign lookup = !mask_vld_reg[st_word_reg.data_byte[ppcs_pkg::CH_IDX_W-1:0]] ? 8'd0
                    : (fwd_hit_reg ? fwd_data_reg : rd_data_reg);

    always_comb begin
        logic [7:0]                    m;
        logic                          apply;
        logic [ppcs_pkg::CH_IDX_W-1:0] ch_m1;
        rows_next    = rows_reg;
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        ch_next      = ch_reg;
        outcome_next = outcome_reg;
        used_next    = used_reg;
        count_next   = count_reg;
        clr_tbl      = 1'b0;
        wr_tbl       = 1'b0;
        apply        = 1'b0;
        m            = 8'd0;
        ch_m1        = '0;
        if (st_word_reg.mode != ppcs_pkg::MODE_CONTINUE) begin
            clr_tbl      = 1'b1;
            if (st_word_reg.mode[1]) begin
                used_next  = '0;
                count_next = '0;
            end
            rows_next    = st_word_reg.row_total;
            phase_next   = PH_CHANNEL;
            skip_next    = '0;
            ch_next      = '0;
            outcome_next = ppcs_pkg::STATUS_BUSY;
        end
        if (outcome_next == ppcs_pkg::STATUS_BUSY) begin
            if (rows_next == 8'd0) begin
                outcome_next = ppcs_pkg::STATUS_DONE;
            end else begin
                case (phase_next)
                    PH_MASK: begin
                        wr_tbl = 1'b1;
                        apply  = 1'b1;
                        m      = st_word_reg.data_byte;
                    end
                    PH_SKIP: begin
                        if (skip_next != '0) begin
                            skip_next = skip_next - 3'd1;
                        end
                        if (skip_next == '0) begin
                            phase_next = PH_CHANNEL;
                        end
                    end
                    default: begin
                        if (st_word_reg.data_byte == 8'd0) begin
                            rows_next = rows_next - 8'd1;
                            if (rows_next == 8'd0) begin
                                outcome_next = ppcs_pkg::STATUS_DONE;
                            end
                        end else begin
                            ch_next = st_word_reg.data_byte[ppcs_pkg::CH_IDX_W-1:0];
                            if (st_word_reg.data_byte[7]) begin
                                phase_next = PH_MASK;
                            end else begin
                                apply = 1'b1;
                                m     = clr_tbl ? 8'd0 : lookup;
                            end
                        end
                    end
                endcase
            end
            ch_m1 = ch_next - 6'd1;
            if (apply) begin
                if (m[0] && (ch_next != '0) && pan_reg[ch_m1] && !used_next[ch_m1]) begin
                    used_next[ch_m1] = 1'b1;
                    count_next       = count_next + 7'd1;
                end
                skip_next  = {2'b00, m[0]} + {2'b00, m[1]} + {2'b00, m[2]} + {1'b0, m[3], 1'b0};
                phase_next = (skip_next != '0) ? PH_SKIP : PH_CHANNEL;
            end
            if ((outcome_next == ppcs_pkg::STATUS_BUSY) && st_word_reg.last_byte) begin
                outcome_next = ppcs_pkg::STATUS_CORRUPT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mask_mem[ch_reg] <= st_word_reg.data_byte;
        end
        if (s_acc) begin
            st_word_reg  <= s_word;
            rd_data_reg  <= mask_mem[s_word.data_byte[ppcs_pkg::CH_IDX_W-1:0]];
            fwd_data_reg <= st_word_reg.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_reg      <= '0;
            imode_reg    <= 1'b0;
            st_vld_reg   <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            mask_vld_reg <= '0;
            rows_reg     <= '0;
            phase_reg    <= PH_CHANNEL;
            skip_reg     <= '0;
            ch_reg       <= '0;
            outcome_reg  <= ppcs_pkg::STATUS_BUSY;
            used_reg     <= '0;
            count_reg    <= '0;
            out_vld_reg  <= 1'b0;
            out_word_reg <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[3] == ppcs_pkg::REG_INSTR_MODE) begin
                    imode_reg <= pwdata[0];
                end else begin
                    pan_reg <= pwdata;
                end
            end
            if (s_acc) begin
                st_vld_reg  <= 1'b1;
                fwd_hit_reg <= wr_en
                               && (ch_reg == s_word.data_byte[ppcs_pkg::CH_IDX_W-1:0]);
            end else if (advance) begin
                st_vld_reg <= 1'b0;
            end
            if (advance) begin
                if (clr_tbl) begin
                    mask_vld_reg <= '0;
                end else if (wr_tbl) begin
                    mask_vld_reg[ch_reg] <= 1'b1;
                end
                rows_reg                   <= rows_next;
                phase_reg                  <= phase_next;
                skip_reg                   <= skip_next;
                ch_reg                     <= ch_next;
                outcome_reg                <= outcome_next;
                used_reg                   <= used_next;
                count_reg                  <= count_next;
                out_vld_reg                <= 1'b1;
                out_word_reg.parse_status  <= outcome_next;
                out_word_reg.used_channels <= used_next;
                out_word_reg.channel_count <= imode_reg ? '0 : count_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    `PPCS_ASSERT_IMPLIES(a_count_matches, aclk, aresetn, 1'b1, count_reg == $countones(used_reg))
    `PPCS_ASSERT_IMPLIES(a_top_bit_unused, aclk, aresetn, 1'b1, !used_reg[ppcs_pkg::CH_SLOTS-1])
    `PPCS_ASSERT_IMPLIES(a_skip_phase, aclk, aresetn, skip_reg != '0, phase_reg == PH_SKIP)
    `PPCS_ASSERT_NEXT(a_ended_holds, aclk, aresetn, ended_step, $stable(used_reg))

endmodule
`default_nettype wire
